// ----- design/ztpsm_pkg.sv -----
// package for the zone time profiler with spike monitor
// shared types, codes and default sizes; no dependencies
`default_nettype none
package ztpsm_pkg;

    localparam int ZONES_DEF   = 32;
    localparam int HISTORY_DEF = 128;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SPIKE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_SPIKE_FLOOR  = 2'd1;
    localparam logic [1:0] CFG_SPIKE_MULT   = 2'd2;
    localparam logic [1:0] CFG_EMA_ALPHA    = 2'd3;

    localparam logic [31:0] SPIKE_FLOOR_RST = 32'd33333333;
    localparam logic [15:0] SPIKE_MULT_RST  = 16'd512;
    localparam logic [15:0] EMA_ALPHA_RST   = 16'd6554;

    // one queued item
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  zone_id;
        logic [31:0] duration_ns;
        logic [47:0] now_ns;
    } t_item;

    // queue head as seen by the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIST,
        S_SPK_MUL,
        S_SPK_CMP,
        S_ZONE,
        S_FOLD,
        S_EMIT,
        S_EMPTY
    } t_state;

endpackage
`default_nettype wire

// ----- design/ztpsm_front.sv -----
// front part: accepts items, drops unknown kinds, queues the rest
// depends on ztpsm_pkg
`default_nettype none
module ztpsm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_kind,
    input  wire  [4:0]          i_zone_id,
    input  wire  [31:0]         i_duration_ns,
    input  wire  [47:0]         i_now_ns,
    input  wire                 i_pop,
    output ztpsm_pkg::t_head    o_head
);

    localparam int DEPTH = 4;

    ztpsm_pkg::t_item r_q [DEPTH];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;

    // accept unless full; unknown kinds are taken and dropped
    assign o_in_stall = (r_cnt == 3'(DEPTH));
    assign push = i_in_valid && !o_in_stall && (i_kind != ztpsm_pkg::KIND_NONE);
    assign pop  = i_pop && (r_cnt != 3'd0);

    assign o_head.valid = (r_cnt != 3'd0);
    assign o_head.item  = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{kind: i_kind, zone_id: i_zone_id,
                           duration_ns: i_duration_ns, now_ns: i_now_ns};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- design/ztpsm_back.sv -----
// back part: zone accumulation, frame history, spike check, zone walk
// depends on ztpsm_pkg
`default_nettype none
module ztpsm_back #(
    parameter int ZONES   = ztpsm_pkg::ZONES_DEF,
    parameter int HISTORY = ztpsm_pkg::HISTORY_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ztpsm_pkg::t_head    i_head,
    output logic                o_pop,
    input  wire                 i_cfg_valid,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [31:0]         i_cfg_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [4:0]          o_row_zone,
    output logic                o_row_valid,
    output logic [15:0]         o_row_calls,
    output logic [31:0]         o_row_last_ns,
    output logic [31:0]         o_row_avg_ns,
    output logic [31:0]         o_row_max_ns,
    output logic [31:0]         o_frame_ns,
    output logic                o_frame_valid,
    output logic                o_spike,
    output logic                o_row_last
);

    localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int SW = 33 + HW;
    localparam int CW = 49 + HW;

    // configuration
    logic        r_en;
    logic [31:0] r_floor;
    logic [15:0] r_mult;
    logic [15:0] r_alpha;

    // frame and history
    logic [47:0]   r_start;
    logic          r_known;
    logic [31:0]   r_hist [HISTORY];
    logic [31:0]   r_hist_q;
    logic [HW:0]   r_hcnt;
    logic [HW-1:0] r_hptr;
    logic [SW-1:0] r_hsum;
    logic [31:0]   r_frame;
    logic          r_fvalid;
    logic          r_spike;
    logic [SW-1:0] r_p1;
    logic [CW-1:0] r_p2;

    // zone state
    logic [31:0] r_total [ZONES];
    logic [15:0] r_calls [ZONES];
    logic [47:0] r_avg   [ZONES];
    logic [31:0] r_max   [ZONES];
    logic [ZONES-1:0] r_seen;

    // walk state
    ztpsm_pkg::t_state r_state, n_state;
    logic [ZW:0]  r_zidx;
    logic         r_any;
    logic         r_last;
    logic [47:0]  r_x;
    logic [47:0]  r_a;
    logic [47:0]  r_d;
    logic         r_up;
    logic [63:0]  r_prod;

    // output register
    logic        r_out_valid;
    logic [4:0]  r_row_zone;
    logic        r_row_valid;
    logic [15:0] r_row_calls;
    logic [31:0] r_row_last_ns;
    logic [31:0] r_row_avg_ns;
    logic [31:0] r_row_max_ns;
    logic [31:0] r_frame_ns;
    logic        r_frame_valid;
    logic        r_spike_o;
    logic        r_row_last;

    logic        out_free;
    logic        out_load;
    logic        pop;
    logic        hist_full;
    logic [ZW-1:0] zsel;
    logic [ZW-1:0] zin;
    logic          zin_ok;
    logic [47:0] el;
    logic [32:0] tsum;
    logic [47:0] new_avg;
    logic [31:0] new_max;
    logic        more;
    logic [47:0] x_cur;
    logic [47:0] a_cur;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign hist_full = (r_hcnt == (HW+1)'(HISTORY));
    assign zsel      = r_zidx[ZW-1:0];
    assign zin       = ZW'({2'b00, i_head.item.zone_id});
    assign zin_ok    = ({2'b00, i_head.item.zone_id} < 7'(ZONES));
    assign el        = i_head.item.now_ns - r_start;
    assign tsum      = {1'b0, r_total[zin]} + {1'b0, i_head.item.duration_ns};
    assign x_cur     = {r_total[zsel], 16'b0};
    assign a_cur     = r_avg[zsel];

    // any seen zone above the current index
    always_comb begin
        more = 1'b0;
        for (int j = 0; j < ZONES; j++) begin
            if (r_seen[j] && ((ZW+1)'(j) > r_zidx)) more = 1'b1;
        end
    end

    // folded average and maximum of the current zone
    always_comb begin
        if (r_calls[zsel] == 16'd0) new_avg = r_a;
        else if (r_a == 48'd0)      new_avg = r_x;
        else if (r_up)              new_avg = r_a + r_prod[63:16];
        else                        new_avg = r_a - r_prod[63:16];
        if (r_calls[zsel] != 16'd0 && r_total[zsel] > r_max[zsel]) new_max = r_total[zsel];
        else                                                        new_max = r_max[zsel];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ztpsm_pkg::S_IDLE: begin
                if (i_head.valid && i_head.item.kind == ztpsm_pkg::KIND_BOUNDARY) begin
                    n_state = r_known ? ztpsm_pkg::S_HIST : ztpsm_pkg::S_ZONE;
                end
            end
            ztpsm_pkg::S_HIST:    n_state = ztpsm_pkg::S_SPK_MUL;
            ztpsm_pkg::S_SPK_MUL: n_state = ztpsm_pkg::S_SPK_CMP;
            ztpsm_pkg::S_SPK_CMP: n_state = ztpsm_pkg::S_ZONE;
            ztpsm_pkg::S_ZONE: begin
                if (r_zidx == (ZW+1)'(ZONES)) begin
                    n_state = r_any ? ztpsm_pkg::S_IDLE : ztpsm_pkg::S_EMPTY;
                end else if (r_seen[zsel]) begin
                    n_state = ztpsm_pkg::S_FOLD;
                end
            end
            ztpsm_pkg::S_FOLD:  n_state = ztpsm_pkg::S_EMIT;
            ztpsm_pkg::S_EMIT:  if (out_free) n_state = ztpsm_pkg::S_ZONE;
            ztpsm_pkg::S_EMPTY: if (out_free) n_state = ztpsm_pkg::S_IDLE;
            default:            n_state = ztpsm_pkg::S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ztpsm_pkg::S_IDLE:  pop = i_head.valid;
            ztpsm_pkg::S_EMIT,
            ztpsm_pkg::S_EMPTY: out_load = out_free;
            default: begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end
    assign o_pop = pop;

    // history memory, registered read at the write pointer
    always_ff @(posedge i_clk) begin
        r_hist_q <= r_hist[r_hptr];
        if (r_state == ztpsm_pkg::S_HIST) r_hist[r_hptr] <= r_frame;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_floor <= ztpsm_pkg::SPIKE_FLOOR_RST;
            r_mult  <= ztpsm_pkg::SPIKE_MULT_RST;
            r_alpha <= ztpsm_pkg::EMA_ALPHA_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ztpsm_pkg::CFG_SPIKE_ENABLE: r_en    <= i_cfg_data[0];
                ztpsm_pkg::CFG_SPIKE_FLOOR:  r_floor <= i_cfg_data;
                ztpsm_pkg::CFG_SPIKE_MULT:   r_mult  <= i_cfg_data[15:0];
                ztpsm_pkg::CFG_EMA_ALPHA:    r_alpha <= i_cfg_data[15:0];
                default:                     r_en    <= r_en;
            endcase
        end
    end

    // frame, history and spike datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ztpsm_pkg::S_IDLE;
            r_start  <= '0;
            r_known  <= 1'b0;
            r_hcnt   <= '0;
            r_hptr   <= '0;
            r_hsum   <= '0;
            r_frame  <= '0;
            r_fvalid <= 1'b0;
            r_spike  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && i_head.item.kind == ztpsm_pkg::KIND_BOUNDARY) begin
                r_frame  <= r_known ? ((|el[47:32]) ? 32'hFFFF_FFFF : el[31:0]) : 32'd0;
                r_fvalid <= r_known;
                r_spike  <= 1'b0;
                r_start  <= i_head.item.now_ns;
                r_known  <= 1'b1;
            end
            if (pop && i_head.item.kind == ztpsm_pkg::KIND_CLEAR) begin
                r_hcnt <= '0;
                r_hptr <= '0;
                r_hsum <= '0;
            end
            if (r_state == ztpsm_pkg::S_HIST) begin
                r_hsum <= r_hsum - (hist_full ? SW'(r_hist_q) : SW'(0)) + SW'(r_frame);
                if (!hist_full) r_hcnt <= r_hcnt + (HW+1)'(1);
                r_hptr <= (r_hptr == HW'(HISTORY - 1)) ? '0 : r_hptr + HW'(1);
            end
            if (r_state == ztpsm_pkg::S_SPK_CMP) begin
                r_spike <= r_en && (r_frame > r_floor) &&
                           (CW'({r_p1, 8'b0}) > r_p2);
            end
        end
    end

    // spike products, one multiply each
    always_ff @(posedge i_clk) begin
        if (r_state == ztpsm_pkg::S_SPK_MUL) begin
            r_p1 <= SW'(r_frame) * SW'(r_hcnt);
            r_p2 <= CW'(r_hsum) * CW'(r_mult);
        end
    end

    // zone state: samples, clears, and folds during the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ZONES; j++) begin
                r_total[j] <= '0;
                r_calls[j] <= '0;
                r_avg[j]   <= '0;
                r_max[j]   <= '0;
            end
            r_seen <= '0;
            r_zidx <= '0;
            r_any  <= 1'b0;
        end else begin
            if (pop && i_head.item.kind == ztpsm_pkg::KIND_SAMPLE && zin_ok) begin
                r_total[zin] <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                if (r_calls[zin] != 16'hFFFF) r_calls[zin] <= r_calls[zin] + 16'd1;
                r_seen[zin] <= 1'b1;
            end
            if (pop && i_head.item.kind == ztpsm_pkg::KIND_CLEAR) begin
                for (int j = 0; j < ZONES; j++) r_max[j] <= '0;
            end
            if (pop && i_head.item.kind == ztpsm_pkg::KIND_BOUNDARY) begin
                r_zidx <= '0;
                r_any  <= 1'b0;
            end
            if (r_state == ztpsm_pkg::S_ZONE && r_zidx != (ZW+1)'(ZONES) && !r_seen[zsel]) begin
                r_zidx <= r_zidx + (ZW+1)'(1);
            end
            if (r_state == ztpsm_pkg::S_EMIT && out_load) begin
                r_avg[zsel]   <= new_avg;
                r_max[zsel]   <= new_max;
                r_total[zsel] <= '0;
                r_calls[zsel] <= '0;
                r_any         <= 1'b1;
                r_zidx        <= r_zidx + (ZW+1)'(1);
            end
        end
    end

    // fold operands and the alpha product
    always_ff @(posedge i_clk) begin
        if (r_state == ztpsm_pkg::S_ZONE) begin
            r_x    <= x_cur;
            r_a    <= a_cur;
            r_up   <= (x_cur >= a_cur);
            r_d    <= (x_cur >= a_cur) ? x_cur - a_cur : a_cur - x_cur;
            r_last <= !more;
        end
        if (r_state == ztpsm_pkg::S_FOLD) begin
            r_prod <= 64'(r_d) * 64'(r_alpha);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_frame_ns    <= r_frame;
            r_frame_valid <= r_fvalid;
            r_spike_o     <= r_spike;
            if (r_state == ztpsm_pkg::S_EMIT) begin
                r_row_zone    <= 5'(r_zidx);
                r_row_valid   <= 1'b1;
                r_row_calls   <= r_calls[zsel];
                r_row_last_ns <= r_total[zsel];
                r_row_avg_ns  <= new_avg[47:16];
                r_row_max_ns  <= new_max;
                r_row_last    <= r_last;
            end else begin
                r_row_zone    <= '0;
                r_row_valid   <= 1'b0;
                r_row_calls   <= '0;
                r_row_last_ns <= '0;
                r_row_avg_ns  <= '0;
                r_row_max_ns  <= '0;
                r_row_last    <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_zone    = r_row_zone;
    assign o_row_valid   = r_row_valid;
    assign o_row_calls   = r_row_calls;
    assign o_row_last_ns = r_row_last_ns;
    assign o_row_avg_ns  = r_row_avg_ns;
    assign o_row_max_ns  = r_row_max_ns;
    assign o_frame_ns    = r_frame_ns;
    assign o_frame_valid = r_frame_valid;
    assign o_spike       = r_spike_o;
    assign o_row_last    = r_row_last;

`ifndef SYNTHESIS
    // history fill never passes its depth
    a_hcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= (HW+1)'(HISTORY))
        else $error("history count overflow");

    // no item is taken from the queue while a boundary is being walked
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ztpsm_pkg::S_IDLE))
        else $error("pop outside idle");

    // a boundary makes the start time known
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_head.item.kind == ztpsm_pkg::KIND_BOUNDARY) |=> r_known)
        else $error("start time not recorded");

    // a row is never loaded over one that is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("held row overwritten");
`endif

endmodule
`default_nettype wire

// ----- design/zone_time_profiler_spike_monitor.sv -----
// zone samples: queued, then zone state updated when popped while the back part is idle;
// one item per cycle sustained unless a boundary walk or a full queue holds the flow
// frame boundary: history, spike multiply and compare (not on the first), then the zone walk,
// which sets the rate: unseen zones skipped, seen ones folded and emitted, else an empty row;
// rows leave through an output register; synchronous active-low reset clears zone state,
// history counters, config; history memory needs no clearing pass; entries written before read
`default_nettype none
module zone_time_profiler_spike_monitor #(
    parameter int ZONES   = ztpsm_pkg::ZONES_DEF,
    parameter int HISTORY = ztpsm_pkg::HISTORY_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_kind,
    input  wire  [4:0]  i_zone_id,
    input  wire  [31:0] i_duration_ns,
    input  wire  [47:0] i_now_ns,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [4:0]  o_row_zone,
    output logic        o_row_valid,
    output logic [15:0] o_row_calls,
    output logic [31:0] o_row_last_ns,
    output logic [31:0] o_row_avg_ns,
    output logic [31:0] o_row_max_ns,
    output logic [31:0] o_frame_ns,
    output logic        o_frame_valid,
    output logic        o_spike,
    output logic        o_row_last
);

    ztpsm_pkg::t_head head;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    // front: accept and queue
    ztpsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_zone_id     (i_zone_id),
        .i_duration_ns (i_duration_ns),
        .i_now_ns      (i_now_ns),
        .i_pop         (pop),
        .o_head        (head)
    );

    // back: execute and emit rows
    ztpsm_back #(
        .ZONES   (ZONES),
        .HISTORY (HISTORY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_zone    (o_row_zone),
        .o_row_valid   (o_row_valid),
        .o_row_calls   (o_row_calls),
        .o_row_last_ns (o_row_last_ns),
        .o_row_avg_ns  (o_row_avg_ns),
        .o_row_max_ns  (o_row_max_ns),
        .o_frame_ns    (o_frame_ns),
        .o_frame_valid (o_frame_valid),
        .o_spike       (o_spike),
        .o_row_last    (o_row_last)
    );

endmodule
`default_nettype wire

// ----- test/zone_time_profiler_spike_monitor_test.sv -----
// testbench for the zone time profiler with spike monitor
// depends on ztpsm_pkg and the zone_time_profiler_spike_monitor top level
`default_nettype none
module zone_time_profiler_spike_monitor_test;

    localparam int NZ = 32;
    localparam int NH = 128;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [4:0]  zone;
        logic        rvalid;
        logic [15:0] calls;
        logic [31:0] last_ns;
        logic [31:0] avg_ns;
        logic [31:0] max_ns;
        logic [31:0] frame;
        logic        fvalid;
        logic        spike;
        logic        last;
    } t_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  zone;
        logic [31:0] dur;
        logic [47:0] now;
        logic        has_row;
        t_row        row;
    } t_vec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [4:0]  i_zone_id = '0;
    logic [31:0] i_duration_ns = '0;
    logic [47:0] i_now_ns = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall, o_cfg_ready, o_out_valid;
    wire  [4:0]  o_row_zone;
    wire         o_row_valid, o_frame_valid, o_spike, o_row_last;
    wire  [15:0] o_row_calls;
    wire  [31:0] o_row_last_ns, o_row_avg_ns, o_row_max_ns, o_frame_ns;

    zone_time_profiler_spike_monitor uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of configuration and state
    logic        m_enable;
    logic [31:0] m_floor;
    logic [15:0] m_mult, m_alpha;
    logic [47:0] m_start;
    logic        m_known;
    logic [31:0] m_hist [NH];
    int          m_hcount, m_hptr;
    logic [63:0] m_hsum;
    logic [31:0] m_total [NZ];
    logic [15:0] m_calls [NZ];
    logic [63:0] m_avg [NZ];
    logic [31:0] m_max [NZ];
    logic        m_seen [NZ];

    t_row rows_due [$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle = 0, recv_stall = 0;

    task automatic profiler_reset();
        m_enable = 0; m_floor = ztpsm_pkg::SPIKE_FLOOR_RST; m_mult = ztpsm_pkg::SPIKE_MULT_RST;
        m_alpha = ztpsm_pkg::EMA_ALPHA_RST; m_start = 0; m_known = 0;
        m_hcount = 0; m_hptr = 0; m_hsum = 0;
        for (int z = 0; z < NZ; z++) begin
            m_total[z] = 0; m_calls[z] = 0; m_avg[z] = 0; m_max[z] = 0; m_seen[z] = 0;
        end
    endtask

    // compute rows caused by one item and queue them
    task automatic profile_item(logic [1:0] kind, logic [4:0] zid, logic [31:0] dur,
                                logic [47:0] now);
        logic [32:0]  t;
        logic [47:0]  el;
        logic [31:0]  frame;
        logic         fv, spk;
        logic [63:0]  x, d;
        t_row         r;
        int           n;
        frame = 0; fv = 0; spk = 0; n = 0;
        case (kind)
            ztpsm_pkg::KIND_SAMPLE: begin
                t = {1'b0, m_total[zid]} + dur;
                m_total[zid] = t[32] ? 32'hFFFF_FFFF : t[31:0];
                if (m_calls[zid] != 16'hFFFF) m_calls[zid]++;
                m_seen[zid] = 1;
            end
            ztpsm_pkg::KIND_BOUNDARY: begin
                if (m_known) begin
                    el = now - m_start;
                    frame = (el > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : el[31:0];
                    fv = 1;
                    if (m_hcount >= NH) m_hsum -= m_hist[m_hptr];
                    else m_hcount++;
                    m_hist[m_hptr] = frame;
                    m_hsum += frame;
                    m_hptr = (m_hptr + 1 >= NH) ? 0 : m_hptr + 1;
                    if (m_enable && frame > m_floor &&
                        64'(frame) * 64'(m_hcount) * 256 > m_hsum * 64'(m_mult))
                        spk = 1;
                end
                m_start = now; m_known = 1;
                for (int z = 0; z < NZ; z++) begin
                    if (!m_seen[z]) continue;
                    if (m_calls[z] != 0) begin
                        x = 64'(m_total[z]) << 16;
                        if (m_avg[z] == 0) m_avg[z] = x;
                        else if (x >= m_avg[z]) begin
                            d = x - m_avg[z]; m_avg[z] += (d * m_alpha) >> 16;
                        end else begin
                            d = m_avg[z] - x; m_avg[z] -= (d * m_alpha) >> 16;
                        end
                        if (m_total[z] > m_max[z]) m_max[z] = m_total[z];
                    end
                    r = '{zone: 5'(z), rvalid: 1, calls: m_calls[z], last_ns: m_total[z],
                          avg_ns: m_avg[z][47:16], max_ns: m_max[z], frame: frame,
                          fvalid: fv, spike: spk, last: 0};
                    rows_due = {rows_due, r};
                    n++;
                    m_total[z] = 0; m_calls[z] = 0;
                end
                if (n == 0) begin
                    r = '0; r.frame = frame; r.fvalid = fv; r.spike = spk;
                    rows_due = {rows_due, r};
                end
                rows_due[$].last = 1;
            end
            ztpsm_pkg::KIND_CLEAR: begin
                for (int z = 0; z < NZ; z++) m_max[z] = 0;
                m_hcount = 0; m_hptr = 0; m_hsum = 0;
            end
            default: ;
        endcase
    endtask

    // output side: random stall and row compare
    always @(posedge i_clk) begin
        t_row got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_row_zone, o_row_valid, o_row_calls, o_row_last_ns, o_row_avg_ns,
                    o_row_max_ns, o_frame_ns, o_frame_valid, o_spike, o_row_last};
            if (rows_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected row %p", got);
            end else begin
                want = rows_due.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("row mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall);

    always @(posedge i_clk)
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end

    // drive one item, with directed row check where given
    task automatic send_item(t_vec v);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1; i_kind <= v.kind; i_zone_id <= v.zone;
        i_duration_ns <= v.dur; i_now_ns <= v.now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        profile_item(v.kind, v.zone, v.dur, v.now);
        if (v.has_row && rows_due.size() > 0 && rows_due[$] !== v.row) begin
            errors++;
            if (errors <= 10) $display("table row mismatch: %p vs %p", v.row, rows_due[$]);
        end
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ztpsm_pkg::CFG_SPIKE_ENABLE: m_enable = val[0];
            ztpsm_pkg::CFG_SPIKE_FLOOR:  m_floor = val;
            ztpsm_pkg::CFG_SPIKE_MULT:   m_mult = val[15:0];
            ztpsm_pkg::CFG_EMA_ALPHA:    m_alpha = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (rows_due.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    t_vec dir_table [] = '{
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'd1000, 1,
          '{5'd0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'd1000, 1,
          '{5'd0, 1'b0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1}},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd0, 32'hFFFF_FFFF, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd0, 32'd5, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd31, 32'd0, 48'hFFFF_FFFF_FFFF, 0, '0},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd7, 32'd100, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'h0, 0, '0},
        '{ztpsm_pkg::KIND_NONE, 5'd31, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, '0},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd7, 32'd50, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 0, '0},
        '{ztpsm_pkg::KIND_CLEAR, 5'd0, 32'd0, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'h0000_4000_0000, 0, '0},
        '{ztpsm_pkg::KIND_SAMPLE, 5'd3, 32'd1, 48'd0, 0, '0},
        '{ztpsm_pkg::KIND_BOUNDARY, 5'd0, 32'd0, 48'h0000_4000_0010, 0, '0}
    };

    task automatic random_phase(int count, int idle, int stall);
        t_vec v;
        logic [47:0] now;
        send_idle = idle; recv_stall = stall;
        now = 48'({$urandom, $urandom});
        for (int i = 0; i < count; i++) begin
            v = '0;
            case ($urandom_range(19))
                0, 1: begin
                    v.kind = ztpsm_pkg::KIND_BOUNDARY;
                    now = now + (($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                                           : 48'($urandom_range(40000000)));
                    v.now = now;
                end
                2: v.kind = ($urandom_range(3) == 0) ? ztpsm_pkg::KIND_NONE
                                                     : ztpsm_pkg::KIND_CLEAR;
                default: begin
                    v.kind = ztpsm_pkg::KIND_SAMPLE;
                    v.zone = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(5));
                    v.dur = ($urandom_range(7) == 0) ? $urandom : $urandom_range(3000000);
                    v.now = 48'({$urandom, $urandom});
                end
            endcase
            send_item(v);
        end
        drain();
    endtask

    initial begin
        profiler_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (dir_table[k]) send_item(dir_table[k]);
        drain();
        write_cfg(ztpsm_pkg::CFG_SPIKE_ENABLE, 32'd1);
        write_cfg(ztpsm_pkg::CFG_SPIKE_FLOOR, 32'd0);
        write_cfg(ztpsm_pkg::CFG_SPIKE_MULT, 32'd256);
        write_cfg(ztpsm_pkg::CFG_EMA_ALPHA, 32'd65535);
        random_phase(115, 0, 0);
        write_cfg(ztpsm_pkg::CFG_SPIKE_FLOOR, 32'hFFFF_FFFF);
        write_cfg(ztpsm_pkg::CFG_SPIKE_MULT, 32'd65535);
        write_cfg(ztpsm_pkg::CFG_EMA_ALPHA, 32'd1);
        random_phase(115, 64, 0);
        write_cfg(ztpsm_pkg::CFG_SPIKE_FLOOR, 32'd10000000);
        write_cfg(ztpsm_pkg::CFG_SPIKE_MULT, 32'd0);
        write_cfg(ztpsm_pkg::CFG_EMA_ALPHA, 32'd32768);
        random_phase(115, 0, 64);
        write_cfg(ztpsm_pkg::CFG_SPIKE_ENABLE, 32'd0);
        write_cfg(ztpsm_pkg::CFG_SPIKE_MULT, 32'd300);
        random_phase(115, 17, 17);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
